@@ sv/uartbd_pkg.sv @@
`timescale 1ns / 1ps

package uartbd_pkg;

  // Field widths
  localparam int BAUD_W = 24;
  localparam int PCLK_W = 28;
  localparam int F_W    = 14;

  // Shared divider geometry
  localparam int DIV_W   = 40;                 // dividend / quotient width
  localparam int DVSR_W  = 28;                 // divisor width
  localparam int CNT_W   = $clog2(DIV_W);

  localparam logic [PCLK_W-1:0] PCLK_RESET = 28'd72000000;
  localparam logic [F_W-1:0]    SCALE      = 14'd10000;
  localparam logic [7:0]        ERR_FACTOR = 8'd200;
  localparam logic [3:0]        MAX_MUL    = 4'd15;
  localparam logic [15:0]       MAX_DIV    = 16'hFFFF;
  localparam logic [7:0]        FRAC_NONE  = 8'h10;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_D,
    ST_CHK_D,
    ST_DIV_R,
    ST_CHK_E,
    ST_DIV_F,
    ST_SEARCH,
    ST_START_A,
    ST_DIV_A,
    ST_FINISH
  } calc_state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic [F_W-1:0] quo;
    logic [3:0]     rem;
  } frac_step_t;

  // Per-add increment of floor(add * 10000 / mul): quotient and remainder of 10000 / mul
  function automatic frac_step_t frac_step(input logic [3:0] mul);
    frac_step_t s;
    s = '0;
    case (mul)
      4'd1:  s = '{quo: F_W'(SCALE / 1),  rem: 4'(SCALE % 1)};
      4'd2:  s = '{quo: F_W'(SCALE / 2),  rem: 4'(SCALE % 2)};
      4'd3:  s = '{quo: F_W'(SCALE / 3),  rem: 4'(SCALE % 3)};
      4'd4:  s = '{quo: F_W'(SCALE / 4),  rem: 4'(SCALE % 4)};
      4'd5:  s = '{quo: F_W'(SCALE / 5),  rem: 4'(SCALE % 5)};
      4'd6:  s = '{quo: F_W'(SCALE / 6),  rem: 4'(SCALE % 6)};
      4'd7:  s = '{quo: F_W'(SCALE / 7),  rem: 4'(SCALE % 7)};
      4'd8:  s = '{quo: F_W'(SCALE / 8),  rem: 4'(SCALE % 8)};
      4'd9:  s = '{quo: F_W'(SCALE / 9),  rem: 4'(SCALE % 9)};
      4'd10: s = '{quo: F_W'(SCALE / 10), rem: 4'(SCALE % 10)};
      4'd11: s = '{quo: F_W'(SCALE / 11), rem: 4'(SCALE % 11)};
      4'd12: s = '{quo: F_W'(SCALE / 12), rem: 4'(SCALE % 12)};
      4'd13: s = '{quo: F_W'(SCALE / 13), rem: 4'(SCALE % 13)};
      4'd14: s = '{quo: F_W'(SCALE / 14), rem: 4'(SCALE % 14)};
      4'd15: s = '{quo: F_W'(SCALE / 15), rem: 4'(SCALE % 15)};
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

@@ sv/uartbd_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
// quotient is valid in the cycle done is high.
module uartbd_div
  import uartbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DVSR_W:0]   rem_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DVSR_W-1:0] dvsr_r;

  logic [DVSR_W:0]   shifted;
  logic              fits;

  // Trial subtract
  assign shifted = {rem_r[DVSR_W-1:0], quo_r[DIV_W-1]};
  assign fits    = (shifted >= {1'b0, dvsr_r});

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out the top, quotient bits shift in the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r  <= req.dividend;
      dvsr_r <= req.divisor;
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? (shifted - {1'b0, dvsr_r}) : shifted;
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ sv/uart_baud_divisor_calculator_unit.sv @@
`timescale 1ns / 1ps

// Steps: an out-of-range result follows the divisor pass alone; without fractional correction
// a rate pass follows; with it, a fraction pass, the add/mul search and an achieved-baud pass.
// Throughput: one transaction at a time; in_ready is high only while the sequencer idles.
// A finished result waits in the output register while the next transaction is taken.
// Reset (rst_n low, synchronous): sequencer idle, no result pending, clock register 72 MHz.
module uart_baud_divisor_calculator_unit
  import uartbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [PCLK_W-1:0] cfg_peripheral_clock_hz,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BAUD_W-1:0] in_requested_baud,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_divisor_low,
  output logic [7:0]        out_divisor_high,
  output logic [7:0]        out_fraction_byte,
  output logic              out_fraction_used,
  output logic [BAUD_W-1:0] out_achieved_baud,
  output logic              out_out_of_range
);

  calc_state_t state_r, state_nxt;

  logic [PCLK_W-1:0] pclk_r;
  logic [BAUD_W-1:0] baud_r;
  logic [PCLK_W-1:0] d_r;
  logic [BAUD_W-1:0] r_r;
  logic [F_W-1:0]    f_r;
  logic [BAUD_W-1:0] ach_r;
  logic              oor_r;
  logic              used_r;

  logic [3:0]        m_r, a_r, bm_r, ba_r, rem_r;
  logic [F_W-1:0]    q_r, best_r;

  logic              out_valid_r;
  logic [7:0]        out_dl_r, out_dh_r, out_frac_r;
  logic              out_used_r, out_oor_r;
  logic [BAUD_W-1:0] out_ach_r;

  div_req_t          div_req;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;

  logic              in_fire;
  logic              d_bad;
  logic [BAUD_W-1:0] diff;
  logic              err_big;
  logic [F_W-1:0]    v;
  logic              last_a;
  frac_step_t        step;
  logic [4:0]        rem_sum;
  logic              out_free;

  uartbd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // Condition terms
  assign d_bad   = (baud_r == '0) || (d_r == '0) || (d_r > PCLK_W'(MAX_DIV));
  assign diff    = r_r - baud_r;
  assign err_big = (r_r > baud_r) &&
                   ((32'(diff) * 32'(ERR_FACTOR)) > 32'(baud_r));

  // Search scoring and add/mul stepping
  assign v       = (f_r >= q_r) ? (f_r - q_r) : (q_r - f_r);
  assign last_a  = (a_r == (m_r - 4'd1));
  assign step    = frac_step(m_r);
  assign rem_sum = {1'b0, rem_r} + {1'b0, step.rem};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_fire) state_nxt = ST_DIV_D;
      ST_DIV_D:   if (div_done) state_nxt = ST_CHK_D;
      ST_CHK_D:   state_nxt = d_bad ? ST_FINISH : ST_DIV_R;
      ST_DIV_R:   if (div_done) state_nxt = ST_CHK_E;
      ST_CHK_E:   state_nxt = err_big ? ST_DIV_F : ST_FINISH;
      ST_DIV_F:   if (div_done) state_nxt = ST_SEARCH;
      ST_SEARCH:  if (last_a && (m_r == MAX_MUL)) state_nxt = ST_START_A;
      ST_START_A: state_nxt = ST_DIV_A;
      ST_DIV_A:   if (div_done) state_nxt = ST_FINISH;
      ST_FINISH:  if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Divider requests
  always_comb begin
    div_req = '0;
    case (state_r)
      ST_IDLE: begin
        div_req.start    = in_fire;
        div_req.dividend = DIV_W'(pclk_r);
        div_req.divisor  = {in_requested_baud, 4'b0000};
      end
      ST_CHK_D: begin
        div_req.start    = !d_bad;
        div_req.dividend = DIV_W'(pclk_r);
        div_req.divisor  = {d_r[DVSR_W-5:0], 4'b0000};
      end
      ST_CHK_E: begin
        div_req.start    = err_big;
        div_req.dividend = DIV_W'(38'(diff) * 38'(SCALE));
        div_req.divisor  = DVSR_W'(baud_r);
      end
      ST_START_A: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(28'(r_r) * 28'(bm_r));
        div_req.divisor  = DVSR_W'({1'b0, bm_r} + {1'b0, ba_r});
      end
      default: div_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pclk_r  <= PCLK_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) pclk_r <= cfg_peripheral_clock_hz;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          baud_r <= in_requested_baud;
          oor_r  <= 1'b0;
          used_r <= 1'b0;
        end
      end
      ST_DIV_D: if (div_done) d_r <= div_quo[PCLK_W-1:0];
      ST_CHK_D: oor_r <= d_bad;
      ST_DIV_R: if (div_done) r_r <= div_quo[BAUD_W-1:0];
      ST_CHK_E: used_r <= err_big;
      ST_DIV_F: begin
        if (div_done) begin
          f_r    <= div_quo[F_W-1:0];
          m_r    <= 4'd1;
          a_r    <= 4'd0;
          q_r    <= '0;
          rem_r  <= 4'd0;
          best_r <= SCALE;
          bm_r   <= 4'd1;
          ba_r   <= 4'd0;
        end
      end
      ST_SEARCH: begin
        // later pairs win ties
        if (v <= best_r) begin
          best_r <= v;
          bm_r   <= m_r;
          ba_r   <= a_r;
        end
        if (last_a) begin
          m_r   <= m_r + 4'd1;
          a_r   <= 4'd0;
          q_r   <= '0;
          rem_r <= 4'd0;
        end else begin
          a_r <= a_r + 4'd1;
          if (rem_sum >= {1'b0, m_r}) begin
            rem_r <= 4'(rem_sum - {1'b0, m_r});
            q_r   <= q_r + step.quo + F_W'(1);
          end else begin
            rem_r <= rem_sum[3:0];
            q_r   <= q_r + step.quo;
          end
        end
      end
      ST_DIV_A: if (div_done) ach_r <= div_quo[BAUD_W-1:0];
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_FINISH) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_FINISH) && out_free) begin
      if (oor_r) begin
        out_dl_r   <= 8'd0;
        out_dh_r   <= 8'd0;
        out_frac_r <= 8'd0;
        out_used_r <= 1'b0;
        out_ach_r  <= '0;
        out_oor_r  <= 1'b1;
      end else begin
        out_dl_r   <= d_r[7:0];
        out_dh_r   <= d_r[15:8];
        out_frac_r <= used_r ? {bm_r, ba_r} : FRAC_NONE;
        out_used_r <= used_r;
        out_ach_r  <= used_r ? ach_r : r_r;
        out_oor_r  <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_divisor_low   = out_dl_r;
  assign out_divisor_high  = out_dh_r;
  assign out_fraction_byte = out_frac_r;
  assign out_fraction_used = out_used_r;
  assign out_achieved_baud = out_ach_r;
  assign out_out_of_range  = out_oor_r;

  // Checks
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV_D || state_r == ST_DIV_R ||
                  state_r == ST_DIV_F || state_r == ST_DIV_A))
    else $error("divider finished outside a wait state");

  a_search_pair_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (a_r < m_r) && (m_r != 4'd0) && (rem_r < m_r))
    else $error("search pair out of range");

  a_oor_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |-> (out_achieved_baud == '0) &&
      (out_fraction_byte == 8'd0) && (out_divisor_low == 8'd0) &&
      (out_divisor_high == 8'd0) && !out_fraction_used)
    else $error("out-of-range result carries data");

  a_no_frac_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_out_of_range && !out_fraction_used) |->
      (out_fraction_byte == FRAC_NONE))
    else $error("fraction byte set without correction");

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_DIV_D))
    else $error("accepted transaction did not start the divisor pass");

endmodule
